### rtl/wbs_pkg.sv
// shared types and constants for the waveform beat sequencer
// no dependencies; imported by every module of the block
package wbs_pkg;

    localparam int WAVE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(WAVE_DEPTH);
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 11;
    localparam int HOLD_W     = 16;
    localparam int FRAME_W    = 14;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // dac command bits above the sample (0011 trimmed to the frame width)
    localparam logic [FRAME_W-SAMPLE_W-1:0] CMD_HI = 2'b11;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD  = 1'b1;

    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_IDLE = 2'd1;
    localparam logic [1:0] PH_PLAY = 2'd2;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 11'd543;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // work handed from the front to the back
    typedef struct packed {
        logic                is_write;
        logic                zero;
        logic                last;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic       pend;
        logic [1:0] phase;
    } front_stat_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0] res_count;
        logic                 rd_busy;
    } back_stat_t;

endpackage

### rtl/wbs_front.sv
// front end: takes input words, runs the beat phase machine, queues commands
// depends on wbs_pkg
module wbs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         operation,
    input  logic [wbs_pkg::ADDR_W-1:0]   sample_address,
    input  logic [wbs_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                         cfg_we,
    input  logic [wbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         q_full,
    output logic                         q_push,
    output wbs_pkg::cmd_t                q_cmd,
    output wbs_pkg::front_stat_t         stat
);
    import wbs_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] play_index_reg, play_index_next;
    logic [HOLD_W-1:0]  hold_count_reg, hold_count_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] sample_count_reg;
    logic [HOLD_W-1:0]  idle_period_reg;

    logic               accept;
    logic [COUNT_W-1:0] index_inc;
    logic [HOLD_W-1:0]  hold_inc;

    assign full      = q_full | pend_reg;
    assign accept    = push & ~full;
    assign index_inc = play_index_reg + COUNT_W'(1);
    assign hold_inc  = hold_count_reg + HOLD_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        play_index_next = play_index_reg;
        hold_count_next = hold_count_reg;
        pend_next       = pend_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        if (pend_reg && !q_full)
        begin
            // second frame of the end-of-beat tick: entry 0
            q_push    = 1'b1;
            q_cmd     = '0;
            q_cmd.last = 1'b1;
            pend_next = 1'b0;
        end
        else if (accept)
        begin
            if (operation == OP_LOAD)
            begin
                q_push         = 1'b1;
                q_cmd.is_write = 1'b1;
                q_cmd.addr     = sample_address;
                q_cmd.value    = sample_value;
            end
            else
            begin
                case (phase_reg)
                    PH_INIT:
                    begin
                        play_index_next = '0;
                        hold_count_next = '0;
                        phase_next      = PH_PLAY;
                    end
                    PH_PLAY:
                    begin
                        q_push     = 1'b1;
                        q_cmd.addr = play_index_reg[ADDR_W-1:0];
                        q_cmd.zero = (32'(play_index_reg) >= WAVE_DEPTH);
                        if (index_inc >= sample_count_reg)
                        begin
                            q_cmd.last      = 1'b0;
                            pend_next       = 1'b1;
                            play_index_next = '0;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            q_cmd.last      = 1'b1;
                            play_index_next = index_inc;
                        end
                    end
                    PH_IDLE:
                    begin
                        if (hold_inc >= idle_period_reg)
                        begin
                            hold_count_next = '0;
                            phase_next      = PH_PLAY;
                        end
                        else
                        begin
                            hold_count_next = hold_inc;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_INIT;
            play_index_reg   <= '0;
            hold_count_reg   <= '0;
            pend_reg         <= 1'b0;
            sample_count_reg <= SAMPLE_COUNT_RST;
            idle_period_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            play_index_reg <= play_index_next;
            hold_count_reg <= hold_count_next;
            pend_reg       <= pend_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_IDLE_PERIOD:  idle_period_reg  <= cfg_data[HOLD_W-1:0];
                    default:          idle_period_reg  <= idle_period_reg;
                endcase
            end
        end
    end

    assign stat.pend  = pend_reg;
    assign stat.phase = phase_reg;

endmodule

### rtl/wbs_cmd_queue.sv
// short command queue between the front and the back
// depends on wbs_pkg
module wbs_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  wbs_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output wbs_pkg::cmd_t rd_cmd,
    output logic          q_empty
);
    import wbs_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr, do_rd;

    assign q_full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? CMD_PTR_W'(32'(wr_ptr_reg) + 1 == CMD_DEPTH ? 0
                                         : 32'(wr_ptr_reg) + 1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? CMD_PTR_W'(32'(rd_ptr_reg) + 1 == CMD_DEPTH ? 0
                                         : 32'(rd_ptr_reg) + 1) : rd_ptr_reg;
        count_next  = count_reg + CMD_CNT_W'(do_wr) - CMD_CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/wbs_back.sv
// back end: waveform store, registered read, frame build and result queue
// depends on wbs_pkg
module wbs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  wbs_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [wbs_pkg::FRAME_W-1:0]  dac_frame,
    output logic                         last,
    output wbs_pkg::back_stat_t          stat
);
    import wbs_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               last;
    } res_t;

    logic [SAMPLE_W-1:0]  mem [WAVE_DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic                 rd_valid_reg;
    logic                 rd_zero_reg;
    logic                 rd_last_reg;

    res_t                 res_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;

    logic                 room;
    logic                 do_read;
    logic                 res_pop;
    logic [SAMPLE_W-1:0]  sample;
    res_t                 head;

    // a read is started only if its result has a slot reserved
    assign room    = (32'(count_reg) + 32'(rd_valid_reg)) < RES_DEPTH;
    assign q_pop   = ~q_empty & (q_cmd.is_write | room);
    assign do_read = q_pop & ~q_cmd.is_write;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.is_write)
        begin
            mem[q_cmd.addr] <= q_cmd.value;
        end
        if (do_read)
        begin
            rd_data_reg <= mem[q_cmd.addr];
            rd_zero_reg <= q_cmd.zero;
            rd_last_reg <= q_cmd.last;
        end
    end

    assign sample  = rd_zero_reg ? '0 : rd_data_reg;
    assign empty   = (count_reg == '0);
    assign res_pop = pop & ~empty;
    assign head    = res_reg[rd_ptr_reg];
    assign dac_frame = head.frame;
    assign last      = head.last;

    always_comb
    begin
        wr_ptr_next = rd_valid_reg ? RES_PTR_W'(32'(wr_ptr_reg) + 1 == RES_DEPTH ? 0
                                                : 32'(wr_ptr_reg) + 1) : wr_ptr_reg;
        rd_ptr_next = res_pop ? RES_PTR_W'(32'(rd_ptr_reg) + 1 == RES_DEPTH ? 0
                                           : 32'(rd_ptr_reg) + 1) : rd_ptr_reg;
        count_next  = count_reg + RES_CNT_W'(rd_valid_reg) - RES_CNT_W'(res_pop);
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            res_reg[wr_ptr_reg] <= '{frame: {CMD_HI, sample}, last: rd_last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= do_read;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    assign stat.res_count = count_reg;
    assign stat.rd_busy   = rd_valid_reg;

endmodule

### rtl/waveform_beat_sequencer.sv
// waveform beat sequencer, top level
// depends on wbs_pkg, wbs_front, wbs_cmd_queue, wbs_back
//
// input side is a queue: a word is taken when push is high and full low.
// operation selects a timer tick or a sample load into the 1024 entry store.
// result side is a queue: while empty is low the oldest frame sits on
// dac_frame/last and is taken when pop is high.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 = sample_count, 1 = idle_period); the user must write only while the
// block is quiet, the block does not enforce it. one input word per cycle
// while full is low; an end-of-beat tick queues two frames and holds full
// high while its second frame is pending. the front issues one command per
// cycle, none while a four deep command queue is full. a play tick's frame
// passes the command queue and store read register into the result queue.
// when pop stays low the four entry result queue fills, the back stops
// draining commands, the command queue fills and full rises.
// reset puts the phase machine in INIT with counters cleared and empties
// both queues; store contents are undefined until loaded.
module waveform_beat_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [wbs_pkg::ADDR_W-1:0]     sample_address,
    input  logic [wbs_pkg::SAMPLE_W-1:0]   sample_value,
    output logic                           empty,
    input  logic                           pop,
    output logic [wbs_pkg::FRAME_W-1:0]    dac_frame,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [wbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wbs_pkg::*;

    logic        cq_full;
    logic        cq_empty;
    logic        cq_push;
    logic        cq_pop;
    cmd_t        cq_wr_cmd;
    cmd_t        cq_rd_cmd;
    front_stat_t front_stat;
    back_stat_t  back_stat;

    wbs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .sample_address (sample_address),
        .sample_value   (sample_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_full         (cq_full),
        .q_push         (cq_push),
        .q_cmd          (cq_wr_cmd),
        .stat           (front_stat)
    );

    wbs_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cq_push),
        .wr_cmd  (cq_wr_cmd),
        .q_full  (cq_full),
        .rd_en   (cq_pop),
        .rd_cmd  (cq_rd_cmd),
        .q_empty (cq_empty)
    );

    wbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (cq_empty),
        .q_cmd     (cq_rd_cmd),
        .q_pop     (cq_pop),
        .empty     (empty),
        .pop       (pop),
        .dac_frame (dac_frame),
        .last      (last),
        .stat      (back_stat)
    );

    // a pending second frame must block new input words
    a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.pend |-> full)
        else $error("input taken while end-of-beat frame pending");

    // pending second frame only follows a play tick that moved to IDLE
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(front_stat.pend) |-> front_stat.phase == PH_IDLE)
        else $error("end-of-beat frame pending outside IDLE");

    // result queue plus a read in flight never exceeds its depth
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        32'(back_stat.res_count) + 32'(back_stat.rd_busy) <= RES_DEPTH)
        else $error("result queue overrun");

    // the back never drains an empty command queue
    a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty)
        else $error("command popped from empty queue");

endmodule

### verif/waveform_beat_sequencer_test.sv
// self-checking bench for the waveform beat sequencer: directed script, then random
// ticks and loads checked against a behavioral player kept in step with the block
// depends on rtl/wbs_pkg.sv and rtl/waveform_beat_sequencer.sv
module waveform_beat_sequencer_test;
    import wbs_pkg::*;

    localparam logic [1:0] BY_MODEL    = 2'd3;  // row expectation comes from the player
    localparam int         NUM_ROWS    = 27;
    localparam int         DRAIN_WAIT  = 12;    // command queue plus pipeline, with margin
    localparam int         HOLD_CYCLES = 400;
    localparam int         QUIET_LIMIT = 3000;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  sel;
        logic                  op;
        logic [ADDR_W-1:0]     addr;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            n;
        logic [FRAME_W-1:0]    f0;
        logic                  l0;
        logic [FRAME_W-1:0]    f1;
        logic                  l1;
    } script_row_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               last;
    } dac_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  operation = OP_TICK;
    logic [ADDR_W-1:0]     sample_address = '0;
    logic [SAMPLE_W-1:0]   sample_value = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [FRAME_W-1:0]    dac_frame;
    logic                  last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // player state kept by the bench
    logic [1:0]          player_phase = PH_INIT;
    logic [COUNT_W-1:0]  play_idx = '0;
    logic [HOLD_W-1:0]   hold_cnt = '0;
    logic [COUNT_W-1:0]  beat_len = SAMPLE_COUNT_RST;
    logic [HOLD_W-1:0]   rest_len = '0;
    logic [SAMPLE_W-1:0] wave [0:WAVE_DEPTH-1];
    bit                  loaded [0:WAVE_DEPTH-1];

    dac_word_t tick_frames [$];
    dac_word_t frames_due [$];
    dac_word_t due_word;
    script_row_t script [NUM_ROWS];

    int errors = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int holds_asked = 0;
    int holds_granted = 0;
    int hold_left = 0;
    int pat_left = 0;
    logic [7:0] pop_pattern = 8'hFF;
    logic [2:0] pat_pos = '0;

    waveform_beat_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .sample_address (sample_address),
        .sample_value   (sample_value),
        .empty          (empty),
        .pop            (pop),
        .dac_frame      (dac_frame),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [FRAME_W-1:0] frame_at(input logic [COUNT_W-1:0] i);
        logic [SAMPLE_W-1:0] s;
        s = (i < WAVE_DEPTH) ? wave[i[ADDR_W-1:0]] : '0;
        return {CMD_HI, s};
    endfunction

    // one accepted word through the player; frames it causes land in tick_frames
    function automatic void advance_player(input logic op, input logic [ADDR_W-1:0] addr,
                                           input logic [SAMPLE_W-1:0] val);
        logic [COUNT_W-1:0] nxt_idx;
        logic [HOLD_W-1:0]  nxt_hold;
        tick_frames.delete();
        if (op == OP_LOAD)
        begin
            wave[addr] = val;
            loaded[addr] = 1'b1;
        end
        else
        begin
            case (player_phase)
                PH_INIT:
                begin
                    play_idx = '0;
                    hold_cnt = '0;
                    player_phase = PH_PLAY;
                end
                PH_PLAY:
                begin
                    nxt_idx = play_idx + 1'b1;
                    if (nxt_idx >= beat_len)
                    begin
                        // end of beat: current sample, then entry 0 closing the beat
                        tick_frames.push_back({frame_at(play_idx), 1'b0});
                        tick_frames.push_back({frame_at('0), 1'b1});
                        play_idx = '0;
                        player_phase = PH_IDLE;
                    end
                    else
                    begin
                        tick_frames.push_back({frame_at(play_idx), 1'b1});
                        play_idx = nxt_idx;
                    end
                end
                PH_IDLE:
                begin
                    nxt_hold = hold_cnt + 1'b1;
                    if (nxt_hold >= rest_len)
                    begin
                        hold_cnt = '0;
                        player_phase = PH_PLAY;
                    end
                    else
                        hold_cnt = nxt_hold;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic script_row_t load_word(input logic [ADDR_W-1:0] addr);
        script_row_t r;
        r = '0;
        r.op = OP_LOAD;
        r.addr = addr;
        r.data = CFG_DATA_W'($urandom_range(0, 4095));
        r.n = BY_MODEL;
        return r;
    endfunction

    task automatic report(input string what, input logic [FRAME_W-1:0] want,
                          input logic [FRAME_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d: %s expected %h got %h", errors, what, want, got);
    endtask

    // offer one word in bursts with random gaps; entered and left at a falling edge
    task automatic send_row(input script_row_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        operation <= r.op;
        sample_address <= r.addr;
        sample_value <= r.data[SAMPLE_W-1:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        advance_player(r.op, r.addr, r.data[SAMPLE_W-1:0]);
        if (r.n == BY_MODEL)
        begin
            foreach (tick_frames[k])
                frames_due.push_back(tick_frames[k]);
        end
        else
        begin
            if (r.n > 0)
                frames_due.push_back({r.f0, r.l0});
            if (r.n > 1)
                frames_due.push_back({r.f1, r.l1});
        end
        @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        push <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_SAMPLE_COUNT)
            beat_len = val[COUNT_W-1:0];
        else
            rest_len = val;
    endtask

    // a tick, preceded by a load when it would play an entry never written
    task automatic play_tick();
        script_row_t r;
        if (player_phase == PH_PLAY && play_idx < WAVE_DEPTH
            && !loaded[play_idx[ADDR_W-1:0]])
            send_row(load_word(play_idx[ADDR_W-1:0]));
        r = '0;
        r.op = OP_TICK;
        r.addr = ADDR_W'($urandom);
        r.data = CFG_DATA_W'($urandom);
        r.n = BY_MODEL;
        send_row(r);
    endtask

    // receiver: own stall pattern, plus a long hold when the stimulus asks for one
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted = holds_asked;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(16, 96);
                pop_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            pat_left--;
            pop <= pop_pattern[pat_pos];
            pat_pos = pat_pos + 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("waveform_beat_sequencer_test NOT OK");
                $finish;
            end
            if (pop && !empty)
            begin
                if (frames_due.size() == 0)
                    report("word with nothing due, dac_frame", '0, dac_frame);
                else
                begin
                    due_word = frames_due.pop_front();
                    if (dac_frame !== due_word.frame)
                        report("dac_frame", due_word.frame, dac_frame);
                    if (last !== due_word.last)
                        report("last", FRAME_W'(due_word.last), FRAME_W'(last));
                end
            end
        end
    end

    initial
    begin : stimulus
        int cnt_pick;
        int idle_pick;
        int phase_n;
        int i;
        script = '{
            // cfg   sel                op        addr     data      n     f0       l0
            //                                                                f1       l1
            '{1'b1, CFG_SAMPLE_COUNT, OP_TICK, 10'd0,   16'd0,    2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_LOAD, 10'd0,   16'hFFF,  2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_LOAD, 10'd1023, 16'h000, 2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            // init tick, then a count of zero acts as one
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd2, 14'h3FFF, 1'b0, 14'h3FFF, 1'b1},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b1, CFG_SAMPLE_COUNT, OP_TICK, 10'd0,   16'd1,    2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd2, 14'h3FFF, 1'b0, 14'h3FFF, 1'b1},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_LOAD, 10'd1,   16'h5A5,  2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b1, CFG_SAMPLE_COUNT, OP_TICK, 10'd0,   16'd2,    2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            // lone frame carries last
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd1, 14'h3FFF, 1'b1, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd2, 14'h35A5, 1'b0, 14'h3FFF, 1'b1},
            // longest hold, then cut short by a lower period
            '{1'b1, CFG_IDLE_PERIOD, OP_TICK, 10'd0,   16'hFFFF, 2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'h3FF, 16'hFFFF, 2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'h3FF, 16'hFFFF, 2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b1, CFG_IDLE_PERIOD, OP_TICK, 10'd0,   16'd1,    2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_LOAD, 10'd0,   16'h000,  2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd1, 14'h3000, 1'b1, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd2, 14'h35A5, 1'b0, 14'h3000, 1'b1},
            '{1'b0, '0, OP_LOAD, 10'd2,   16'hA5A,  2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b1, CFG_SAMPLE_COUNT, OP_TICK, 10'd0,   16'd3,    2'd0,
              14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    2'd0, 14'h0,    1'b0, 14'h0,    1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    BY_MODEL, 14'h0, 1'b0, 14'h0,   1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    BY_MODEL, 14'h0, 1'b0, 14'h0,   1'b0},
            '{1'b0, '0, OP_TICK, 10'd0,   16'd0,    BY_MODEL, 14'h0, 1'b0, 14'h0,   1'b0}
        };
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            if (script[k].is_cfg)
                write_reg(script[k].sel, script[k].data);
            else
                send_row(script[k]);
        end

        for (phase_n = 0; phase_n < 14; phase_n++)
        begin
            case ($urandom_range(0, 7))
                0: cnt_pick = 0;
                1: cnt_pick = 1;
                2: cnt_pick = $urandom_range(17, 64);
                default: cnt_pick = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 5))
                0: idle_pick = $urandom_range(0, 65535);
                1: idle_pick = 0;
                default: idle_pick = $urandom_range(1, 6);
            endcase
            write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(cnt_pick));
            write_reg(CFG_IDLE_PERIOD, CFG_DATA_W'(idle_pick));
            for (i = 0; i < 110; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_row(load_word(($urandom_range(0, 9) == 0) ?
                                       ADDR_W'($urandom_range(0, 1023)) :
                                       ADDR_W'($urandom_range(0, 63))));
                else
                    play_tick();
            end
            if (phase_n == 1)
            begin
                // receiver holds off while play ticks keep making words
                write_reg(CFG_SAMPLE_COUNT, 16'd1);
                write_reg(CFG_IDLE_PERIOD, 16'd0);
                holds_asked++;
                for (i = 0; i < 60; i++)
                    play_tick();
            end
        end

        // count equal to the store depth, then a short run of ticks
        write_reg(CFG_IDLE_PERIOD, 16'd0);
        write_reg(CFG_SAMPLE_COUNT, 16'd1024);
        for (i = 0; i < 40; i++)
            play_tick();

        push <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0)
            $display("waveform_beat_sequencer_test OK");
        else
            $display("waveform_beat_sequencer_test NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/wbs_pkg.sv
rtl/wbs_front.sv
rtl/wbs_cmd_queue.sv
rtl/wbs_back.sv
rtl/waveform_beat_sequencer.sv
verif/waveform_beat_sequencer_test.sv
